// ----- rtl/core/pasp_pkg.sv -----
// Shared types and constants for the preferential attachment stub picker.
package pasp_pkg;

	// Configuration register indexes.
	localparam logic [1:0] REG_INIT_VERTICES  = 2'd0;
	localparam logic [1:0] REG_EDGES_PER_VERT = 2'd1;
	localparam logic [1:0] REG_TOTAL_STEPS    = 2'd2;

	// Result status codes.
	localparam logic [1:0] ST_EDGE   = 2'd0;
	localparam logic [1:0] ST_INIT   = 2'd1;
	localparam logic [1:0] ST_FULL   = 2'd2;
	localparam logic [1:0] ST_REJECT = 2'd3;

	// Input command codes.
	localparam logic CMD_INIT   = 1'b0;
	localparam logic CMD_ATTACH = 1'b1;

	// Largest number of edges a new vertex may make.
	localparam int unsigned MAX_EDGES = 16;

	// Datapath micro-operations issued by the controller, one per cycle.
	typedef enum logic [4:0] {
		OP_NONE,
		OP_LATCH,
		OP_INIT_BAD,
		OP_INIT_START,
		OP_INIT_FILL,
		OP_LIMIT,
		OP_MUL,
		OP_IDX,
		OP_RDV,
		OP_RDD,
		OP_ROT_RD,
		OP_ROT_WR,
		OP_ROT_END,
		OP_SCAN_RD,
		OP_SCAN_CMP,
		OP_MOVE_SETUP,
		OP_MV_RD,
		OP_MV_WR,
		OP_MV_END,
		OP_APP_V,
		OP_DEG_V,
		OP_DEG_URD,
		OP_DEG_UWR,
		OP_BOOK,
		OP_APP_U,
		OP_STEP_END,
		OP_RESULT
	} op_t;

	typedef struct packed {
		op_t        op;
		logic [1:0] res_status;
	} dp_cmd_t;

	typedef struct packed {
		logic cmd_attach;
		logic cfg_bad;
		logic active;
		logic store_full;
		logic fill_last;
		logic d_zero;
		logic rot_more;
		logic scan_ok;
		logic scan_match;
		logic mv_more;
		logic app_v_more;
		logic step_end;
		logic app_u_more;
	} dp_stat_t;

endpackage

// ----- rtl/core/pasp_dp.sv -----
// Datapath of the stub picker: registers, stub store, degree table and result register.
module pasp_dp #(
	parameter int MAX_VERTICES = 1024,
	parameter int MAX_STUBS    = 4096
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [1:0]        cfg_index,
	input  logic [10:0]       cfg_data,
	input  logic              command,
	input  logic [31:0]       random_word,
	input  pasp_pkg::dp_cmd_t cmd,
	output pasp_pkg::dp_stat_t stat,
	output logic [9:0]        new_vertex,
	output logic [9:0]        chosen_vertex,
	output logic              last_of_step,
	output logic              graph_done,
	output logic [1:0]        status
);
	import pasp_pkg::*;

	localparam int AW  = $clog2(MAX_STUBS);
	localparam int NW  = AW + 1;
	localparam int VW  = $clog2(MAX_VERTICES);
	localparam int CW  = VW + 1;
	localparam int KW0 = (NW > CW) ? NW : CW;
	localparam int KW  = (KW0 > 13) ? KW0 : 13;
	localparam int PW  = 32 + NW;

	// Configuration and run registers.
	logic [10:0]   init_vertices_q;
	logic [4:0]    edges_cfg_q;
	logic [9:0]    steps_cfg_q;
	logic [4:0]    run_edges_q;
	logic [9:0]    run_steps_q;
	logic [NW-1:0] stub_count_q;
	logic [AW-1:0] limit_q;
	logic [CW-1:0] vertex_count_q;
	logic [4:0]    choice_q;
	logic [9:0]    steps_done_q;
	logic          active_q;
	logic          last_q;

	// Working registers of one item.
	logic          cmd_q;
	logic [31:0]   r_q;
	logic [PW-1:0] prod_q;
	logic [AW-1:0] idx_q;
	logic [VW-1:0] v_q;
	logic [VW-1:0] u_q;
	logic [11:0]   d_q;
	logic [KW-1:0] k_q;
	logic [KW-1:0] e_q;
	logic [KW-1:0] s_q;

	// Result register.
	logic [9:0] res_new_q;
	logic [9:0] res_chosen_q;
	logic       res_last_q;
	logic       res_done_q;
	logic [1:0] res_status_q;

	// Memories and their ports.
	logic [VW-1:0] stub_mem [MAX_STUBS];
	logic [11:0]   deg_mem  [MAX_VERTICES];
	logic          stub_we;
	logic [AW-1:0] stub_wa;
	logic [VW-1:0] stub_wd;
	logic [AW-1:0] stub_ra;
	logic [VW-1:0] stub_rdata;
	logic          deg_we;
	logic [VW-1:0] deg_wa;
	logic [11:0]   deg_wd;
	logic [VW-1:0] deg_ra;
	logic [11:0]   deg_rdata;

	// Widened views for comparisons.
	logic [KW-1:0] n_k;
	logic [KW-1:0] lim_k;
	logic [KW-1:0] d_k;
	logic [KW-1:0] edges_k;
	logic [KW-1:0] maxs_k;
	logic [KW-1:0] n0_k;
	logic [NW-1:0] idx_raw;
	logic [AW-1:0] idx_next;
	logic [NW-1:0] lim1;
	logic [31:0]   n0_w;
	logic [31:0]   m_w;
	logic [31:0]   t_w;

	assign n_k     = KW'(stub_count_q);
	assign lim_k   = KW'(limit_q);
	assign d_k     = KW'(d_q);
	assign edges_k = KW'(run_edges_q);
	assign maxs_k  = KW'(MAX_STUBS);
	assign n0_k    = KW'(init_vertices_q);
	assign lim1    = NW'(limit_q) + NW'(1);
	assign n0_w    = 32'(init_vertices_q);
	assign m_w     = 32'(edges_cfg_q);
	assign t_w     = 32'(steps_cfg_q);

	// Scaled pick, clamped into the filled part of the store.
	always_comb begin
		idx_raw = prod_q[PW-1:32];
		if (idx_raw >= stub_count_q) begin
			idx_next = (stub_count_q != '0) ? AW'(stub_count_q - NW'(1)) : '0;
		end else begin
			idx_next = AW'(idx_raw);
		end
	end

	// Status flags for the controller.
	always_comb begin
		stat.cmd_attach = (cmd_q == CMD_ATTACH);
		stat.cfg_bad    = (n0_w == 0) || (m_w == 0) || (m_w > MAX_EDGES) || (m_w > n0_w) ||
		                  (t_w == 0) || (n0_w > 32'(MAX_STUBS)) ||
		                  (n0_w + t_w > 32'(MAX_VERTICES));
		stat.active     = active_q;
		stat.store_full = (choice_q == '0) &&
		                  (32'(stub_count_q) + 32'(run_edges_q) * 2 > 32'(MAX_STUBS));
		stat.fill_last  = (k_q == KW'(MAX_VERTICES - 1));
		stat.d_zero     = (d_q == '0);
		stat.rot_more   = (k_q < lim_k);
		stat.scan_ok    = (e_q <= lim_k) && (e_q < n_k);
		stat.scan_match = (stub_rdata == v_q);
		stat.mv_more    = (k_q < n_k);
		stat.app_v_more = (k_q <= d_k) && (n_k < maxs_k);
		stat.step_end   = (choice_q >= run_edges_q);
		stat.app_u_more = (k_q < edges_k) && (n_k < maxs_k);
	end

	// Memory port selection.
	always_comb begin
		stub_we = 1'b0;
		stub_wa = '0;
		stub_wd = '0;
		stub_ra = '0;
		deg_we  = 1'b0;
		deg_wa  = '0;
		deg_wd  = '0;
		deg_ra  = '0;
		case (cmd.op)
			OP_INIT_FILL: begin
				stub_we = (k_q < n0_k);
				stub_wa = AW'(k_q);
				stub_wd = VW'(k_q);
				deg_we  = 1'b1;
				deg_wa  = VW'(k_q);
			end
			OP_IDX:     stub_ra = idx_next;
			OP_RDV:     deg_ra = stub_rdata;
			OP_ROT_RD:  stub_ra = AW'(k_q + KW'(1));
			OP_ROT_WR: begin
				stub_we = 1'b1;
				stub_wa = AW'(k_q);
				stub_wd = stub_rdata;
			end
			OP_ROT_END: begin
				stub_we = 1'b1;
				stub_wa = limit_q;
				stub_wd = v_q;
			end
			OP_SCAN_RD: stub_ra = AW'(e_q);
			OP_MV_RD:   stub_ra = AW'(k_q);
			OP_MV_WR: begin
				stub_we = 1'b1;
				stub_wa = AW'(s_q);
				stub_wd = stub_rdata;
			end
			OP_APP_V: begin
				stub_we = 1'b1;
				stub_wa = AW'(stub_count_q);
				stub_wd = v_q;
			end
			OP_APP_U: begin
				stub_we = 1'b1;
				stub_wa = AW'(stub_count_q);
				stub_wd = u_q;
			end
			OP_DEG_V: begin
				deg_we = 1'b1;
				deg_wa = v_q;
				deg_wd = d_q + 12'd1;
			end
			OP_DEG_URD: deg_ra = u_q;
			OP_DEG_UWR: begin
				deg_we = 1'b1;
				deg_wa = u_q;
				deg_wd = deg_rdata + 12'd1;
			end
			default: ;
		endcase
	end

	// Stub store with registered read.
	always_ff @(posedge clk) begin
		if (stub_we) begin
			stub_mem[stub_wa] <= stub_wd;
		end
		stub_rdata <= stub_mem[stub_ra];
	end

	// Degree table with registered read.
	always_ff @(posedge clk) begin
		if (deg_we) begin
			deg_mem[deg_wa] <= deg_wd;
		end
		deg_rdata <= deg_mem[deg_ra];
	end

	// Configuration, run and graph state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init_vertices_q <= 11'd1;
			edges_cfg_q     <= 5'd1;
			steps_cfg_q     <= 10'd1;
			run_edges_q     <= '0;
			run_steps_q     <= '0;
			stub_count_q    <= '0;
			limit_q         <= '0;
			vertex_count_q  <= '0;
			choice_q        <= '0;
			steps_done_q    <= '0;
			active_q        <= 1'b0;
			last_q          <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_INIT_VERTICES:  init_vertices_q <= cfg_data;
					REG_EDGES_PER_VERT: edges_cfg_q <= cfg_data[4:0];
					REG_TOTAL_STEPS:    steps_cfg_q <= cfg_data[9:0];
					default: ;
				endcase
			end
			case (cmd.op)
				OP_LATCH: last_q <= 1'b0;
				OP_INIT_BAD: begin
					active_q     <= 1'b0;
					run_steps_q  <= '0;
					run_edges_q  <= '0;
					steps_done_q <= '0;
					choice_q     <= '0;
				end
				OP_INIT_START: begin
					run_edges_q    <= edges_cfg_q;
					run_steps_q    <= steps_cfg_q;
					stub_count_q   <= NW'(init_vertices_q);
					limit_q        <= AW'(init_vertices_q - 11'd1);
					vertex_count_q <= CW'(init_vertices_q);
					choice_q       <= '0;
					steps_done_q   <= '0;
					active_q       <= 1'b1;
				end
				OP_LIMIT: begin
					if (choice_q == '0) begin
						limit_q <= (stub_count_q != '0) ? AW'(stub_count_q - NW'(1)) : '0;
					end
				end
				OP_ROT_END: begin
					if (limit_q != '0) begin
						limit_q <= limit_q - AW'(1);
					end
				end
				OP_MV_END: begin
					stub_count_q <= NW'(s_q);
					limit_q      <= (lim_k >= d_k) ? AW'(lim_k - d_k) : '0;
				end
				OP_APP_V, OP_APP_U: stub_count_q <= stub_count_q + NW'(1);
				OP_BOOK: choice_q <= choice_q + 5'd1;
				OP_STEP_END: begin
					choice_q       <= '0;
					vertex_count_q <= vertex_count_q + CW'(1);
					steps_done_q   <= steps_done_q + 10'd1;
					last_q         <= 1'b1;
					if (11'(steps_done_q) + 11'd1 >= 11'(run_steps_q)) begin
						active_q <= 1'b0;
					end
				end
				default: ;
			endcase
		end
	end

	// Working registers and the result register.
	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_LATCH: begin
				cmd_q <= command;
				r_q   <= random_word;
			end
			OP_INIT_START: k_q <= '0;
			OP_INIT_FILL:  k_q <= k_q + KW'(1);
			OP_MUL:        prod_q <= PW'(r_q) * PW'(lim1);
			OP_IDX:        idx_q <= idx_next;
			OP_RDV: begin
				v_q <= stub_rdata;
				u_q <= VW'(vertex_count_q);
			end
			OP_RDD: begin
				d_q <= deg_rdata;
				k_q <= KW'(idx_q);
				e_q <= KW'(idx_q);
			end
			OP_ROT_WR: k_q <= k_q + KW'(1);
			OP_SCAN_CMP: begin
				if (stub_rdata == v_q) begin
					e_q <= e_q + KW'(1);
				end
			end
			OP_MOVE_SETUP: begin
				s_q <= (d_k <= e_q) ? e_q - d_k : '0;
				k_q <= e_q;
			end
			OP_MV_WR: begin
				k_q <= k_q + KW'(1);
				s_q <= s_q + KW'(1);
			end
			OP_MV_END, OP_BOOK: k_q <= '0;
			OP_APP_V, OP_APP_U: k_q <= k_q + KW'(1);
			OP_RESULT: begin
				res_status_q <= cmd.res_status;
				res_done_q   <= (run_steps_q != '0) && (steps_done_q >= run_steps_q);
				if (cmd.res_status == ST_EDGE) begin
					res_new_q    <= 10'(u_q);
					res_chosen_q <= 10'(v_q);
					res_last_q   <= last_q;
				end else begin
					res_new_q    <= '0;
					res_chosen_q <= '0;
					res_last_q   <= 1'b0;
				end
			end
			default: ;
		endcase
	end

	assign new_vertex    = res_new_q;
	assign chosen_vertex = res_chosen_q;
	assign last_of_step  = res_last_q;
	assign graph_done    = res_done_q;
	assign status        = res_status_q;

endmodule

// ----- rtl/core/pasp_ctrl.sv -----
// Controller of the stub picker: sequences datapath operations and the handshakes.
module pasp_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	output logic               out_valid,
	input  logic               out_stall,
	input  pasp_pkg::dp_stat_t stat,
	output pasp_pkg::dp_cmd_t  cmd
);
	import pasp_pkg::*;

	typedef enum logic [4:0] {
		S_IDLE, S_DECIDE, S_FILL, S_MUL, S_IDX, S_RDV, S_RDD, S_BRANCH,
		S_ROT, S_ROT_W, S_SCAN, S_SCAN_C, S_MVS, S_MV, S_MV_W, S_APPV,
		S_DEGV, S_DEGUR, S_DEGUW, S_BOOK, S_CHK, S_APPU, S_RESULT
	} state_t;

	state_t     state_q, state_d;
	logic [1:0] pend_q, pend_d;
	logic       out_valid_q;
	logic       slot_free;

	assign slot_free = !out_valid_q || !out_stall;
	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;

	// Next state and the operation issued this cycle.
	always_comb begin
		state_d        = state_q;
		pend_d         = pend_q;
		cmd.op         = OP_NONE;
		cmd.res_status = pend_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.op  = OP_LATCH;
					state_d = S_DECIDE;
				end
			end
			S_DECIDE: begin
				if (!stat.cmd_attach) begin
					if (stat.cfg_bad) begin
						cmd.op  = OP_INIT_BAD;
						pend_d  = ST_REJECT;
						state_d = S_RESULT;
					end else begin
						cmd.op  = OP_INIT_START;
						state_d = S_FILL;
					end
				end else if (!stat.active) begin
					pend_d  = ST_REJECT;
					state_d = S_RESULT;
				end else if (stat.store_full) begin
					pend_d  = ST_FULL;
					state_d = S_RESULT;
				end else begin
					cmd.op  = OP_LIMIT;
					state_d = S_MUL;
				end
			end
			S_FILL: begin
				cmd.op = OP_INIT_FILL;
				if (stat.fill_last) begin
					pend_d  = ST_INIT;
					state_d = S_RESULT;
				end
			end
			S_MUL: begin
				cmd.op  = OP_MUL;
				state_d = S_IDX;
			end
			S_IDX: begin
				cmd.op  = OP_IDX;
				state_d = S_RDV;
			end
			S_RDV: begin
				cmd.op  = OP_RDV;
				state_d = S_RDD;
			end
			S_RDD: begin
				cmd.op  = OP_RDD;
				state_d = S_BRANCH;
			end
			S_BRANCH: state_d = stat.d_zero ? S_ROT : S_SCAN;
			S_ROT: begin
				if (stat.rot_more) begin
					cmd.op  = OP_ROT_RD;
					state_d = S_ROT_W;
				end else begin
					cmd.op  = OP_ROT_END;
					state_d = S_DEGV;
				end
			end
			S_ROT_W: begin
				cmd.op  = OP_ROT_WR;
				state_d = S_ROT;
			end
			S_SCAN: begin
				if (stat.scan_ok) begin
					cmd.op  = OP_SCAN_RD;
					state_d = S_SCAN_C;
				end else begin
					state_d = S_MVS;
				end
			end
			S_SCAN_C: begin
				cmd.op  = OP_SCAN_CMP;
				state_d = stat.scan_match ? S_SCAN : S_MVS;
			end
			S_MVS: begin
				cmd.op  = OP_MOVE_SETUP;
				state_d = S_MV;
			end
			S_MV: begin
				if (stat.mv_more) begin
					cmd.op  = OP_MV_RD;
					state_d = S_MV_W;
				end else begin
					cmd.op  = OP_MV_END;
					state_d = S_APPV;
				end
			end
			S_MV_W: begin
				cmd.op  = OP_MV_WR;
				state_d = S_MV;
			end
			S_APPV: begin
				if (stat.app_v_more) begin
					cmd.op = OP_APP_V;
				end else begin
					state_d = S_DEGV;
				end
			end
			S_DEGV: begin
				cmd.op  = OP_DEG_V;
				state_d = S_DEGUR;
			end
			S_DEGUR: begin
				cmd.op  = OP_DEG_URD;
				state_d = S_DEGUW;
			end
			S_DEGUW: begin
				cmd.op  = OP_DEG_UWR;
				state_d = S_BOOK;
			end
			S_BOOK: begin
				cmd.op  = OP_BOOK;
				state_d = S_CHK;
			end
			S_CHK: begin
				if (stat.step_end) begin
					state_d = S_APPU;
				end else begin
					pend_d  = ST_EDGE;
					state_d = S_RESULT;
				end
			end
			S_APPU: begin
				if (stat.app_u_more) begin
					cmd.op = OP_APP_U;
				end else begin
					cmd.op  = OP_STEP_END;
					pend_d  = ST_EDGE;
					state_d = S_RESULT;
				end
			end
			S_RESULT: begin
				if (slot_free) begin
					cmd.op  = OP_RESULT;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// State, pending status and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			pend_q      <= ST_EDGE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			pend_q  <= pend_d;
			if (state_q == S_RESULT && slot_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ----- rtl/core/preferential_attachment_stub_picker.sv -----
// Top level of the preferential attachment stub picker.
//
//   channel   direction  handshake            payload
//   in        input      in_valid / in_stall   command, random_word
//   out       output     out_valid / out_stall new_vertex, chosen_vertex, last_of_step,
//                                              graph_done, status
//   cfg       input      cfg_we               cfg_index, cfg_data
//
// One item at a time. Init is a sweep over the degree table, one entry a cycle, that also
// writes the starting stubs. An attach takes longer when the chosen vertex has a nonzero
// degree and at the end of a step, and its work grows with each store entry read by the
// rotation, the block scan and the close-up move, and with each stub appended. Reset clears
// the control, configuration and run state only; the stub store, degree table, working and
// result registers are not reset.
// A finished result waits in the output register while out_stall is high; the next item
// is taken once that result has moved to the output register.
module preferential_attachment_stub_picker #(
	parameter int MAX_VERTICES = 1024,
	parameter int MAX_STUBS    = 4096
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [10:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        command,
	input  logic [31:0] random_word,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [9:0]  new_vertex,
	output logic [9:0]  chosen_vertex,
	output logic        last_of_step,
	output logic        graph_done,
	output logic [1:0]  status
);
	import pasp_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;

	// Sequencer.
	pasp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	// Storage and arithmetic.
	pasp_dp #(
		.MAX_VERTICES (MAX_VERTICES),
		.MAX_STUBS    (MAX_STUBS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.command       (command),
		.random_word   (random_word),
		.cmd           (cmd),
		.stat          (stat),
		.new_vertex    (new_vertex),
		.chosen_vertex (chosen_vertex),
		.last_of_step  (last_of_step),
		.graph_done    (graph_done),
		.status        (status)
	);

	// An accepted item always puts the block to work.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("input transfer did not start work");

	// Results other than an edge carry empty edge fields.
	a_reject_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status != ST_EDGE) |->
		(new_vertex == '0 && chosen_vertex == '0 && !last_of_step))
		else $error("non-edge result carries edge fields");

	// A fresh graph is never done.
	a_init_not_done: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status == ST_INIT) |-> !graph_done)
		else $error("init result reports graph done");

endmodule
